// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/sipnis_pkg.sv =====
package sipnis_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 24;

   // event codes
   localparam logic [2:0] EV_PEER      = 3'd0;
   localparam logic [2:0] EV_TU        = 3'd1;
   localparam logic [2:0] EV_TCP_READY = 3'd2;
   localparam logic [2:0] EV_TX_FAILED = 3'd3;
   localparam logic [2:0] EV_TIMEOUT   = 3'd4;

   // send outcome codes; the unused code counts as sent
   localparam logic [1:0] SEND_OK         = 2'd0;
   localparam logic [1:0] SEND_CONNECTING = 2'd1;
   localparam logic [1:0] SEND_FAILED     = 2'd2;

   // transaction state codes as seen on state_now
   localparam logic [2:0] STATE_NONE       = 3'd0;
   localparam logic [2:0] STATE_TRYING     = 3'd1;
   localparam logic [2:0] STATE_PROCEEDING = 3'd2;
   localparam logic [2:0] STATE_COMPLETED  = 3'd3;
   localparam logic [2:0] STATE_TERMINATED = 3'd4;

   localparam logic [9:0] CODE_PROV_MIN  = 10'd100;
   localparam logic [9:0] CODE_PROV_MAX  = 10'd199;
   localparam logic [9:0] CODE_FINAL_MIN = 10'd200;
   localparam logic [9:0] CODE_FINAL_MAX = 10'd699;

   localparam logic [7:0] TIMER_FIRST = 8'd1;

   typedef struct packed {
      logic       is_request;
      logic [2:0] cmd;
   } req_user_type;

   typedef struct packed {
      logic [3:0] pad;
      logic [7:0] timer_id;
      logic [1:0] send_status;
      logic [9:0] rsp_code;
   } req_data_type;

   typedef struct packed {
      logic [5:0] pad;
      logic [2:0] state_now;
      logic       released;
      logic [7:0] timer_out;
      logic       stop_timer;
      logic       start_timer;
      logic       report_error;
      logic       deliver_request;
      logic       send_response;
      logic       status;
   } rsp_data_type;

endpackage

// ===== sv/sip_non_invite_server_fsm_unit.sv =====
// Non-INVITE SIP server transaction engine.
// Request channel (req_): one event per request. req_tuser carries the event
// kind and the message kind, req_tdata the response code, the outcome of the
// send that the event causes, and the expired timer id.
// Response channel (rsp_): exactly one result per request, in order: status,
// action pulses (send response, deliver request, report error, start/stop
// timer J, release), timer id and the state after the event.
// A request taken on req_ is held in the request register; its result is
// then registered in the result register and shown on rsp_. Throughput: one
// request per cycle while rsp_tready is high; the state update is one pass
// of next-state logic between the request register and the result register.
// Stall: while rsp_tready is low the result holds and one more request is
// taken into the request register; req_tready then drops until the result
// is taken.
// Reset (synchronous, active high) clears both valid flags and returns the
// transaction to none, with no timer armed and the timer id counter at one.
module sip_non_invite_server_fsm_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [2:0] cmd, [3] is_request
   input  logic [sipnis_pkg::REQ_USER_W-1:0]      req_tuser,
   // [9:0] rsp_code, [11:10] send_status, [19:12] timer_id, [23:20] zero
   input  logic [sipnis_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] status, [1] send_response, [2] deliver_request, [3] report_error,
   // [4] start_timer, [5] stop_timer, [13:6] timer_out, [14] released,
   // [17:15] state_now, [23:18] zero
   output logic [sipnis_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import sipnis_pkg::*;

   typedef enum logic [2:0] {
      S_NONE       = STATE_NONE,
      S_TRYING     = STATE_TRYING,
      S_PROCEEDING = STATE_PROCEEDING,
      S_COMPLETED  = STATE_COMPLETED,
      S_TERMINATED = STATE_TERMINATED
   } state_type;

   state_type    state_ff, state_in;
   logic [9:0]   code_ff, code_in;
   logic         tcp_ff, tcp_in;
   logic [7:0]   held_ff, held_in;
   logic [7:0]   next_id_ff, next_id_in;

   logic         in_valid_ff;
   req_user_type in_user_ff;
   req_data_type in_data_ff;
   logic         out_valid_ff;
   rsp_data_type out_data_ff, out_data_in;

   logic         step;
   logic         bad;
   logic         do_adv;
   logic         allow_prov;
   logic         do_term;
   logic         term_report;
   logic [7:0]   next_id_inc;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || step);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign next_id_inc = next_id_ff + 8'd1;

   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      tcp_in      = tcp_ff;
      held_in     = held_ff;
      next_id_in  = next_id_ff;
      out_data_in = '0;
      bad         = 1'b0;
      do_adv      = 1'b0;
      allow_prov  = 1'b0;
      do_term     = 1'b0;
      term_report = 1'b0;

      case (state_ff)
         S_NONE: begin
            if (in_user_ff.cmd == EV_PEER) begin
               state_in = S_TRYING;
               out_data_in.deliver_request = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         S_TRYING, S_PROCEEDING: begin
            if (in_user_ff.cmd == EV_TU) begin
               if (in_user_ff.is_request) begin
                  bad = 1'b1;
               end else begin
                  code_in = in_data_ff.rsp_code;
                  if (in_data_ff.send_status == SEND_FAILED) begin
                     do_term     = 1'b1;
                     term_report = 1'b1;
                  end else if (in_data_ff.send_status == SEND_CONNECTING) begin
                     tcp_in = 1'b1;
                  end else begin
                     tcp_in = 1'b0;
                     out_data_in.send_response = 1'b1;
                     do_adv     = 1'b1;
                     allow_prov = (state_ff == S_TRYING);
                  end
               end
            end else if (in_user_ff.cmd == EV_TCP_READY) begin
               tcp_in = 1'b1;
               if (in_data_ff.send_status == SEND_FAILED) begin
                  do_term     = 1'b1;
                  term_report = 1'b1;
               end else begin
                  out_data_in.send_response = 1'b1;
                  do_adv     = 1'b1;
                  allow_prov = (state_ff == S_TRYING);
               end
            end else if (in_user_ff.cmd == EV_PEER && state_ff == S_PROCEEDING) begin
               if (!in_user_ff.is_request) begin
                  bad = 1'b1;
               end else if (in_data_ff.send_status == SEND_FAILED) begin
                  do_term     = 1'b1;
                  term_report = 1'b1;
               end else begin
                  out_data_in.send_response = 1'b1;
               end
            end else if (in_user_ff.cmd == EV_TX_FAILED && state_ff == S_PROCEEDING) begin
               do_term     = 1'b1;
               term_report = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         S_COMPLETED: begin
            case (in_user_ff.cmd)
               EV_TU: begin
                  bad = in_user_ff.is_request;
               end
               EV_PEER: begin
                  if (!in_user_ff.is_request) begin
                     bad = 1'b1;
                  end else if (in_data_ff.send_status == SEND_FAILED) begin
                     do_term = 1'b1;
                  end else if (in_data_ff.send_status != SEND_CONNECTING) begin
                     out_data_in.send_response = 1'b1;
                  end
               end
               EV_TCP_READY: begin
                  tcp_in = 1'b1;
                  if (in_data_ff.send_status == SEND_FAILED) begin
                     do_term = 1'b1;
                  end else begin
                     out_data_in.send_response = 1'b1;
                  end
               end
               EV_TX_FAILED: begin
                  do_term     = 1'b1;
                  term_report = 1'b1;
               end
               EV_TIMEOUT: begin
                  if (in_data_ff.timer_id != held_ff) begin
                     bad = 1'b1;
                  end else begin
                     // expired timer needs no stop
                     held_in = '0;
                     do_term = 1'b1;
                  end
               end
               default: begin
                  bad = 1'b1;
               end
            endcase
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      // move on after a good send, by the stored code
      if (do_adv) begin
         if (allow_prov && (code_in inside {[CODE_PROV_MIN:CODE_PROV_MAX]})) begin
            state_in = S_PROCEEDING;
         end else if (code_in inside {[CODE_FINAL_MIN:CODE_FINAL_MAX]}) begin
            if (!tcp_in) begin
               state_in = S_COMPLETED;
               held_in  = next_id_ff;
               out_data_in.start_timer = 1'b1;
               out_data_in.timer_out   = next_id_ff;
               next_id_in = (next_id_inc == 8'd0) ? TIMER_FIRST : next_id_inc;
            end else begin
               do_term = 1'b1;
            end
         end
      end

      if (do_term) begin
         state_in = S_TERMINATED;
         out_data_in.report_error = term_report;
         if (held_in != 8'd0) begin
            out_data_in.stop_timer = 1'b1;
            out_data_in.timer_out  = held_in;
            held_in = '0;
         end
         out_data_in.released = 1'b1;
      end

      if (bad) begin
         state_in    = state_ff;
         code_in     = code_ff;
         tcp_in      = tcp_ff;
         held_in     = held_ff;
         next_id_in  = next_id_ff;
         out_data_in = '0;
         out_data_in.status = 1'b1;
      end

      out_data_in.state_now = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= S_NONE;
         code_ff      <= '0;
         tcp_ff       <= 1'b0;
         held_ff      <= '0;
         next_id_ff   <= TIMER_FIRST;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_user_ff  <= req_user_type'(req_tuser);
            in_data_ff  <= req_data_type'(req_tdata);
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= out_data_in;
            state_ff     <= state_in;
            code_ff      <= code_in;
            tcp_ff       <= tcp_in;
            held_ff      <= held_in;
            next_id_ff   <= next_id_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== sv/sipnis_checker.sv =====
`include "assert_macros.svh"

module sipnis_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sipnis_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sipnis_pkg::*;

   rsp_data_type rsp;
   logic         timer_pulse;

   assign rsp         = rsp_data_type'(rsp_tdata);
   assign timer_pulse = rsp.start_timer || rsp.stop_timer;

   // a rejected event has no side effects
   `ASSERT_IMPLIES(a_invalid_quiet, clock, reset, rsp_tvalid && rsp.status,
      !rsp.send_response && !rsp.deliver_request && !rsp.report_error && !timer_pulse && !rsp.released && rsp.timer_out == 8'd0)

   // timer id is nonzero exactly when a timer pulse is shown, never both pulses
   `ASSERT_IMPLIES(a_timer_id, clock, reset, rsp_tvalid,
      (timer_pulse == (rsp.timer_out != 8'd0)) && !(rsp.start_timer && rsp.stop_timer))

   `ASSERT_IMPLIES(a_release_state, clock, reset, rsp_tvalid && rsp.released,
      rsp.state_now == STATE_TERMINATED)

   `ASSERT_IMPLIES(a_deliver_state, clock, reset, rsp_tvalid && rsp.deliver_request,
      rsp.state_now == STATE_TRYING && !rsp.send_response)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sip_non_invite_server_fsm_unit sipnis_checker u_sipnis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
